// ===== design/hlbf_pkg.sv =====
// Shared types and constants for the hop-limited shortest path block.
`default_nettype none
package hlbf_pkg;

   localparam int NODE_BITS  = 6;
   localparam int NODE_SPAN  = 1 << NODE_BITS;
   localparam int NCNT_BITS  = 7;
   localparam int STOP_BITS  = 6;
   localparam int COST_BITS  = 16;
   localparam int DIST_BITS  = 24;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 7;
   localparam int REQ_DATA_BITS = 32;

   localparam logic [DIST_BITS-1:0] INF_MARK = {DIST_BITS{1'b1}};
   localparam logic [DIST_BITS-1:0] SAT_MAX  = INF_MARK - DIST_BITS'(1);

   localparam logic [NCNT_BITS-1:0] NODE_COUNT_RST = NCNT_BITS'(64);

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_NODE_COUNT  = 2'd0,
      CSR_SOURCE_NODE = 2'd1,
      CSR_DEST_NODE   = 2'd2,
      CSR_MAX_STOPS   = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [COST_BITS-1:0] edge_cost;
      logic [NODE_BITS-1:0] to_node;
      logic [NODE_BITS-1:0] from_node;
   } edge_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_INIT,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_EDGE_RD,
      ST_DIST_RD,
      ST_SUM,
      ST_RELAX,
      ST_ROUND_END,
      ST_RES_RD,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

// ===== design/hlbf_dist_store.sv =====
// Double-banked distance store with per-entry valid bits; invalid entries read as infinity.
`default_nettype none
module hlbf_dist_store #(
   parameter int IDX_W = 6
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           clear,
   input  wire logic                           wr_en,
   input  wire logic [IDX_W:0]                 wr_addr,
   input  wire logic [hlbf_pkg::DIST_BITS-1:0] wr_data,
   input  wire logic [IDX_W:0]                 rd0_addr,
   input  wire logic [IDX_W:0]                 rd1_addr,
   output logic      [hlbf_pkg::DIST_BITS-1:0] rd0_data,
   output logic      [hlbf_pkg::DIST_BITS-1:0] rd1_data
);
   import hlbf_pkg::*;

   localparam int SLOTS = 2 << IDX_W;

   logic [DIST_BITS-1:0] dist_mem_ff [SLOTS];
   logic [SLOTS-1:0]     valid_ff;
   logic [DIST_BITS-1:0] rd0_ff;
   logic [DIST_BITS-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dist_mem_ff[wr_addr] <= wr_data;
      end
      rd0_ff <= valid_ff[rd0_addr] ? dist_mem_ff[rd0_addr] : INF_MARK;
      rd1_ff <= valid_ff[rd1_addr] ? dist_mem_ff[rd1_addr] : INF_MARK;
   end

   assign rd0_data = rd0_ff;
   assign rd1_data = rd1_ff;

endmodule
`default_nettype wire

// ===== design/hop_limited_bellman_ford.sv =====
// Edge words load at one per cycle while idle; a word with tlast runs (max_stops+1) relaxation rounds.
// Each round copies N distances, N = min(MAX_NODES,64), then relaxes each of the E stored edges
// (edge read, distance read, sum, relax) through one shared add/compare unit and the
// two-read-port distance store.
// No word is accepted during a run; a finished result waits in the rsp register.
// Reset is synchronous: control state and configuration registers to defaults; no clearing pass.
`default_nettype none
module hop_limited_bellman_ford #(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [hlbf_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [hlbf_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // from_node[5:0], to_node[11:6], edge_cost[27:12], zero[31:28]
   input  wire logic [hlbf_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic                               req_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // cheapest_cost[23:0]
   output logic      [hlbf_pkg::DIST_BITS-1:0]     rsp_tdata,
   // reachable[0]
   output logic                                    rsp_tuser
);
   import hlbf_pkg::*;

   localparam int DEPTH      = (MAX_NODES < NODE_SPAN) ? MAX_NODES : NODE_SPAN;
   localparam int NODE_IDX_W = $clog2(DEPTH);
   localparam int EC_W       = $clog2(MAX_EDGES + 1);
   localparam int EI_W       = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam logic [NCNT_BITS-1:0]  NODE_LIM  = NCNT_BITS'(DEPTH);
   localparam logic [NODE_IDX_W-1:0] NODE_LAST = NODE_IDX_W'(DEPTH - 1);
   localparam logic [EC_W-1:0]       EDGE_MAX  = EC_W'(MAX_EDGES);

   state_type state_ff, state_in;

   logic [NCNT_BITS-1:0] node_count_ff;
   logic [NODE_BITS-1:0] source_node_ff;
   logic [NODE_BITS-1:0] dest_node_ff;
   logic [STOP_BITS-1:0] max_stops_ff;

   edge_type             edge_mem_ff [MAX_EDGES];
   edge_type             edge_rd_ff;
   edge_type             req_edge;
   logic [EC_W-1:0]      edge_cnt_ff;
   logic [EC_W-1:0]      edge_idx_ff;
   logic [NODE_IDX_W-1:0] node_idx_ff;
   logic [STOP_BITS-1:0] round_ff;
   logic                 bank_ff;
   logic [DIST_BITS-1:0] sum_ff;
   logic                 ok_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_reach_ff;
   logic [DIST_BITS-1:0] rsp_cost_ff;

   logic                 req_fire;
   logic                 edge_room;
   logic                 from_ok, to_ok, src_ok, dest_ok;
   logic [DIST_BITS:0]   sum_wide;
   logic [DIST_BITS-1:0] sum_sat;
   logic                 emit_go;
   logic                 last_edge_done;

   logic                  dist_clear;
   logic                  dist_we;
   logic [NODE_IDX_W:0]   dist_wa;
   logic [DIST_BITS-1:0]  dist_wd;
   logic [NODE_IDX_W:0]   dist_ra0;
   logic [NODE_IDX_W:0]   dist_ra1;
   logic [DIST_BITS-1:0]  rd0_data;
   logic [DIST_BITS-1:0]  rd1_data;

   assign req_edge  = edge_type'(req_tdata[2*NODE_BITS+COST_BITS-1:0]);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire  = req_tvalid && req_tready;
   assign edge_room = (edge_cnt_ff < EDGE_MAX);

   assign from_ok = (NCNT_BITS'(edge_rd_ff.from_node) < node_count_ff)
                 && (NCNT_BITS'(edge_rd_ff.from_node) < NODE_LIM);
   assign to_ok   = (NCNT_BITS'(edge_rd_ff.to_node) < node_count_ff)
                 && (NCNT_BITS'(edge_rd_ff.to_node) < NODE_LIM);
   assign src_ok  = (NCNT_BITS'(source_node_ff) < node_count_ff)
                 && (NCNT_BITS'(source_node_ff) < NODE_LIM);
   assign dest_ok = (NCNT_BITS'(dest_node_ff) < node_count_ff)
                 && (NCNT_BITS'(dest_node_ff) < NODE_LIM);

   assign sum_wide = {1'b0, rd0_data} + (DIST_BITS+1)'(edge_rd_ff.edge_cost);
   assign sum_sat  = (sum_wide >= {1'b0, INF_MARK}) ? SAT_MAX : sum_wide[DIST_BITS-1:0];

   assign emit_go        = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign last_edge_done = ((edge_idx_ff + EC_W'(1)) == edge_cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tlast) state_in = ST_START;
         end
         ST_START:   state_in = ST_INIT;
         ST_INIT:    state_in = ST_COPY_RD;
         ST_COPY_RD: state_in = ST_COPY_WR;
         ST_COPY_WR: begin
            if (node_idx_ff == NODE_LAST) begin
               state_in = (edge_cnt_ff != '0) ? ST_EDGE_RD : ST_ROUND_END;
            end else begin
               state_in = ST_COPY_RD;
            end
         end
         ST_EDGE_RD: state_in = ST_DIST_RD;
         ST_DIST_RD: state_in = ST_SUM;
         ST_SUM:     state_in = ST_RELAX;
         ST_RELAX:   state_in = last_edge_done ? ST_ROUND_END : ST_EDGE_RD;
         ST_ROUND_END: begin
            state_in = (round_ff == max_stops_ff) ? ST_RES_RD : ST_COPY_RD;
         end
         ST_RES_RD:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_go) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // distance store control
   always_comb begin
      dist_clear = 1'b0;
      dist_we    = 1'b0;
      dist_wa    = {~bank_ff, node_idx_ff};
      dist_wd    = rd0_data;
      dist_ra0   = {bank_ff, edge_rd_ff.from_node[NODE_IDX_W-1:0]};
      dist_ra1   = {~bank_ff, edge_rd_ff.to_node[NODE_IDX_W-1:0]};
      unique case (state_ff) inside
         ST_START: dist_clear = 1'b1;
         ST_INIT: begin
            dist_we = src_ok;
            dist_wa = {bank_ff, source_node_ff[NODE_IDX_W-1:0]};
            dist_wd = '0;
         end
         ST_COPY_RD: dist_ra0 = {bank_ff, node_idx_ff};
         ST_COPY_WR: dist_we  = 1'b1;
         ST_RELAX: begin
            dist_we = ok_ff && (sum_ff < rd1_data);
            dist_wa = {~bank_ff, edge_rd_ff.to_node[NODE_IDX_W-1:0]};
            dist_wd = sum_ff;
         end
         ST_RES_RD, ST_EMIT: dist_ra0 = {bank_ff, dest_node_ff[NODE_IDX_W-1:0]};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff  <= NODE_COUNT_RST;
         source_node_ff <= '0;
         dest_node_ff   <= '0;
         max_stops_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_NODE_COUNT:  node_count_ff  <= csr_wdata[NCNT_BITS-1:0];
            CSR_SOURCE_NODE: source_node_ff <= csr_wdata[NODE_BITS-1:0];
            CSR_DEST_NODE:   dest_node_ff   <= csr_wdata[NODE_BITS-1:0];
            CSR_MAX_STOPS:   max_stops_ff   <= csr_wdata[STOP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && edge_room) begin
         edge_mem_ff[edge_cnt_ff[EI_W-1:0]] <= req_edge;
      end
      edge_rd_ff <= edge_mem_ff[edge_idx_ff[EI_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         edge_cnt_ff  <= '0;
         edge_idx_ff  <= '0;
         node_idx_ff  <= '0;
         round_ff     <= '0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && edge_room) edge_cnt_ff <= edge_cnt_ff + EC_W'(1);
               edge_idx_ff <= '0;
               node_idx_ff <= '0;
               round_ff    <= '0;
               bank_ff     <= 1'b0;
            end
            ST_COPY_WR: begin
               node_idx_ff <= (node_idx_ff == NODE_LAST) ? '0
                                                         : node_idx_ff + NODE_IDX_W'(1);
            end
            ST_RELAX: begin
               edge_idx_ff <= last_edge_done ? '0 : edge_idx_ff + EC_W'(1);
            end
            ST_ROUND_END: begin
               bank_ff  <= ~bank_ff;
               round_ff <= round_ff + STOP_BITS'(1);
            end
            ST_EMIT: begin
               if (emit_go) edge_cnt_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         sum_ff <= sum_sat;
         ok_ff  <= from_ok && to_ok && (rd0_data != INF_MARK);
      end
      if (emit_go) begin
         rsp_reach_ff <= dest_ok && (rd0_data != INF_MARK);
         rsp_cost_ff  <= (dest_ok && (rd0_data != INF_MARK)) ? rd0_data : '0;
      end
   end

   hlbf_dist_store #(
      .IDX_W (NODE_IDX_W)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .clear    (dist_clear),
      .wr_en    (dist_we),
      .wr_addr  (dist_wa),
      .wr_data  (dist_wd),
      .rd0_addr (dist_ra0),
      .rd1_addr (dist_ra1),
      .rd0_data (rd0_data),
      .rd1_data (rd1_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_cost_ff;
   assign rsp_tuser  = rsp_reach_ff;

   a_edge_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      edge_cnt_ff <= EDGE_MAX)
      else $error("edge count past store depth");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> (rsp_valid_ff && (edge_cnt_ff == '0) && (state_ff == ST_IDLE)))
      else $error("result emit did not post word and empty edge store");

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_reach_ff) |-> (rsp_cost_ff == '0))
      else $error("unreachable result carries a cost");

   a_reach_finite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_reach_ff) |-> (rsp_cost_ff != INF_MARK))
      else $error("reachable result carries infinity");

endmodule
`default_nettype wire

// ===== dv/tb_hop_limited_bellman_ford.sv =====
// Self-checking testbench for hop_limited_bellman_ford: edge streams in, route results checked.
`timescale 1ns / 1ps
module tb_hop_limited_bellman_ford;
   import hlbf_pkg::*;

   localparam int STORE_DEPTH   = 1024;
   localparam int RANDOM_WORDS  = 1950;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 3000;
   localparam int LIMIT_CYCLES  = 2000000;

   typedef struct packed {
      logic     is_last;
      edge_type arc;
   } link_word_type;

   typedef struct packed {
      logic                 reachable;
      logic [DIST_BITS-1:0] cost;
   } route_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [DIST_BITS-1:0]     rsp_tdata;
   logic                     rsp_tuser;

   link_word_type pending_edges[$];
   route_type     expected_routes[$];

   edge_type    graph_edges[STORE_DEPTH];
   int unsigned graph_edge_count = 0;

   logic [NCNT_BITS-1:0] cfg_node_count = NODE_COUNT_RST;
   logic [NODE_BITS-1:0] cfg_source = '0;
   logic [NODE_BITS-1:0] cfg_dest = '0;
   logic [STOP_BITS-1:0] cfg_stops = '0;

   int unsigned idle_mode = 0;
   int unsigned send_idle_pct[3] = '{19, 81, 0};
   int unsigned recv_idle_pct[3] = '{81, 19, 0};
   logic        hold_start = 1'b0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned words_accepted = 0;
   int unsigned routes_checked = 0;
   int unsigned routes_reached = 0;
   int unsigned settings_count = 0;

   hop_limited_bellman_ford u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // hop-limited relaxation over the stored graph with the current register copy
   function automatic route_type shortest_route();
      logic [DIST_BITS-1:0] dist_now [NODE_SPAN];
      logic [DIST_BITS-1:0] dist_new [NODE_SPAN];
      logic [DIST_BITS:0]   path_sum;
      int unsigned          active;
      route_type            res;
      edge_type             arc;
      active = (cfg_node_count > NODE_SPAN) ? NODE_SPAN : cfg_node_count;
      foreach (dist_now[i]) dist_now[i] = INF_MARK;
      if (cfg_source < active) dist_now[cfg_source] = '0;
      for (int rnd = 0; rnd <= cfg_stops; rnd++) begin
         dist_new = dist_now;
         for (int e = 0; e < graph_edge_count; e++) begin
            arc = graph_edges[e];
            if (arc.from_node < active && arc.to_node < active &&
                dist_now[arc.from_node] != INF_MARK) begin
               path_sum = {1'b0, dist_now[arc.from_node]} + arc.edge_cost;
               if (path_sum >= INF_MARK) path_sum = {1'b0, SAT_MAX};
               if (path_sum < dist_new[arc.to_node]) begin
                  dist_new[arc.to_node] = path_sum[DIST_BITS-1:0];
               end
            end
         end
         dist_now = dist_new;
      end
      if (cfg_dest < active && dist_now[cfg_dest] != INF_MARK) begin
         res.reachable = 1'b1;
         res.cost      = dist_now[cfg_dest];
      end else begin
         res.reachable = 1'b0;
         res.cost      = '0;
      end
      return res;
   endfunction

   // edge driver
   always @(posedge clock) begin : drive_edges
      link_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_edges.size() != 0 && $urandom_range(99) >= send_idle_pct[idle_mode]) begin
            w = pending_edges.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_DATA_BITS'(w.arc);
            req_tlast  <= w.is_last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // predictor on accepted edge words
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         words_accepted++;
         if (graph_edge_count < STORE_DEPTH) begin
            graph_edges[graph_edge_count] = edge_type'(req_tdata[$bits(edge_type)-1:0]);
            graph_edge_count++;
         end
         if (req_tlast) begin
            expected_routes = {expected_routes, shortest_route()};
            graph_edge_count = 0;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_start) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // result monitor
   always @(posedge clock) begin : check_routes
      route_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_routes.size() == 0) begin
               flag_error($sformatf("unexpected result reach=%0b cost=%0d",
                                    rsp_tuser, rsp_tdata));
            end else begin
               want = expected_routes.pop_front();
               routes_checked++;
               if (want.reachable) routes_reached++;
               if (rsp_tuser !== want.reachable)
                  flag_error($sformatf("route %0d reachable: got %b want %b",
                                       routes_checked, rsp_tuser, want.reachable));
               if (rsp_tdata !== want.cost)
                  flag_error($sformatf("route %0d cost: got %0d want %0d",
                                       routes_checked, rsp_tdata, want.cost));
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct[idle_mode]);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d routes outstanding",
                  cycle_count, expected_routes.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
   endtask

   task automatic configure(input logic [NCNT_BITS-1:0] nodes, input logic [NODE_BITS-1:0] src,
                            input logic [NODE_BITS-1:0] dst, input logic [STOP_BITS-1:0] stops);
      write_reg(CSR_NODE_COUNT, nodes);
      write_reg(CSR_SOURCE_NODE, CSR_DATA_BITS'(src));
      write_reg(CSR_DEST_NODE, CSR_DATA_BITS'(dst));
      write_reg(CSR_MAX_STOPS, CSR_DATA_BITS'(stops));
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_node_count = nodes;
      cfg_source     = src;
      cfg_dest       = dst;
      cfg_stops      = stops;
      settings_count++;
   endtask

   task automatic push_edge(input int unsigned src, input int unsigned dst,
                            input int unsigned cost, input bit is_last);
      link_word_type w;
      w.arc.from_node = NODE_BITS'(src);
      w.arc.to_node   = NODE_BITS'(dst);
      w.arc.edge_cost = COST_BITS'(cost);
      w.is_last       = is_last;
      pending_edges = {pending_edges, w};
   endtask

   // drain: all words sent, all results back, then let the block go idle
   task automatic settle();
      while (pending_edges.size() != 0 || req_tvalid || expected_routes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly inside the active node range, sometimes anywhere
   function automatic logic [NODE_BITS-1:0] pick_node(input int unsigned span);
      if ($urandom_range(9) == 0) return NODE_BITS'($urandom_range(NODE_SPAN - 1));
      return NODE_BITS'($urandom_range(span - 1));
   endfunction

   function automatic int unsigned pick_cost();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 45) return $urandom_range(65535);
      if (r < 75) return $urandom_range(15);
      if (r < 88) return 0;
      return 65535;
   endfunction

   task automatic push_random_graph(input int unsigned n, input int unsigned span,
                                    inout int unsigned sent);
      for (int i = 0; i < n; i++)
         push_edge(pick_node(span), pick_node(span), pick_cost(), i == n - 1);
      sent += n;
   endtask

   initial begin : stimulus
      int unsigned          random_sent;
      int unsigned          phase;
      int unsigned          r;
      int unsigned          span;
      int unsigned          graphs;
      int unsigned          max_size;
      logic [NCNT_BITS-1:0] nc;
      logic [STOP_BITS-1:0] stops;
      bit                   store_filled;
      random_sent  = 0;
      phase        = 0;
      store_filled = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed graphs
      configure(64, 0, 0, 0);
      push_edge(0, 0, 16'h0000, 1);
      settle();
      configure(64, 0, 63, 2);
      push_edge(0, 1, 16'hAAAA, 0);
      push_edge(1, 63, 16'h5555, 0);
      push_edge(0, 63, 16'hFFFF, 1);
      settle();
      // edges touching nodes past the active count are ignored
      configure(5, 0, 4, 0);
      push_edge(0, 63, 1, 0);
      push_edge(63, 4, 1, 0);
      push_edge(0, 4, 7, 1);
      settle();
      configure(3, 10, 10, 0);
      push_edge(10, 10, 0, 1);
      settle();
      configure(0, 0, 0, 5);
      push_edge(0, 0, 1, 1);
      settle();
      configure(127, 63, 0, 63);
      push_edge(63, 0, 1, 1);
      settle();
      configure(64, 0, 2, 0);
      push_edge(0, 1, 3, 0);
      push_edge(1, 2, 3, 1);
      settle();
      configure(1, 0, 0, 0);
      push_edge(0, 0, 5, 1);
      settle();
      configure(64, 0, 3, 1);
      push_edge(0, 1, 1, 0);
      push_edge(1, 2, 1, 0);
      push_edge(2, 3, 1, 0);
      push_edge(0, 3, 100, 0);
      push_edge(1, 3, 50, 1);
      settle();
      configure(4, 0, 9, 3);
      push_edge(0, 9, 1, 1);
      settle();

      // random graphs
      while (random_sent < RANDOM_WORDS) begin
         idle_mode = (random_sent * 3) / RANDOM_WORDS;
         if (idle_mode > 2) idle_mode = 2;
         if (!store_filled && random_sent >= 500) begin
            // overfill the edge store; words past its depth are dropped
            configure(64, pick_node(NODE_SPAN), pick_node(NODE_SPAN), 1);
            push_random_graph(STORE_DEPTH + 6, NODE_SPAN, random_sent);
            store_filled = 1;
            settle();
         end
         r = $urandom_range(99);
         if (r < 5) nc = 0;
         else if (r < 10) nc = 1;
         else if (r < 16) nc = NCNT_BITS'($urandom_range(127, 65));
         else if (r < 26) nc = 64;
         else nc = NCNT_BITS'($urandom_range(64, 2));
         span = (nc == 0 || nc > NODE_SPAN) ? NODE_SPAN : nc;
         r = $urandom_range(99);
         if (r < 75) stops = STOP_BITS'($urandom_range(4));
         else if (r < 93) stops = STOP_BITS'($urandom_range(16, 5));
         else stops = 63;
         configure(nc, pick_node(span), pick_node(span), stops);
         max_size = (stops > 16) ? 12 : 40;
         graphs = $urandom_range(4, 1);
         if (phase % 12 == 5) begin
            graphs = 4;
            @(posedge clock);
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         repeat (graphs) begin
            if ($urandom_range(99) < 70)
               push_random_graph($urandom_range(10, 1), span, random_sent);
            else
               push_random_graph($urandom_range(max_size, 11), span, random_sent);
         end
         settle();
         phase++;
      end

      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (expected_routes.size() != 0)
         flag_error($sformatf("%0d routes never returned", expected_routes.size()));
      $display("Run covered %0d edge words, %0d routes checked (%0d reachable)",
               words_accepted, routes_checked, routes_reached);
      $display("across %0d register settings, including an overfilled edge store",
               settings_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
